[sv/bpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and fixed-point helpers of the particle push unit.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int unsigned NumStages = 46;
  localparam int unsigned DivFirst = 5;
  localparam int unsigned DivSteps = 33;

  localparam logic [30:0] TimeStepRst = 31'd838861;
  localparam logic [31:0] HalfDtQmRst = 32'hFFF9_999A;
  localparam logic [30:0] BoxLenRst = 31'd268435456;

  localparam int unsigned Next1 [3] = '{1, 2, 0};
  localparam int unsigned Next2 [3] = '{2, 0, 1};

  typedef enum logic [2:0] {
    CfgTimeStep = 3'd0,
    CfgHalfDtQm = 3'd1,
    CfgBoxLenX  = 3'd2,
    CfgBoxLenY  = 3'd3,
    CfgBoxLenZ  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][30:0] pos;
    logic [2:0][33:0] pw;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] k;
    logic [2:0][31:0] t;
    logic [2:0][31:0] vm;
    logic [2:0][31:0] vp;
    logic [2:0][31:0] vn;
    logic [2:0][31:0] s;
    logic [31:0]      den;
    logic [2:0][63:0] prod_a;
    logic [2:0][63:0] prod_b;
    logic [2:0][31:0] rem;
    logic [2:0][32:0] num;
    logic [2:0][32:0] quo;
    logic [2:0]       neg;
  } push_t;

  function automatic logic signed [41:0] ext_q(input logic [31:0] v);
    return 42'($signed(v));
  endfunction

  function automatic logic [31:0] sat_q(input logic signed [41:0] x);
    logic [31:0] r;
    if (x > 42'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -42'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mul_q(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    logic signed [63:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic [31:0] rnd_q(input logic [63:0] p);
    logic signed [63:0] x;
    x = $signed(p) + 64'sd8388608;
    return sat_q(42'(x >>> 24));
  endfunction

endpackage

[sv/boris_particle_push_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_particle_push_unit
// Fixed-point Boris push of one particle per request with periodic wrap.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start_i high and busy_o low. It
// carries the position, velocity and the electric and magnetic field of one
// particle. busy_o stays low, so a request can be given in every cycle and
// the unit takes one particle per cycle.
// The result of a request shows on the new_* ports for one cycle, marked by
// done_o, once it has passed the last pipeline stage. Results leave in
// request order. The receiver cannot hold them off and none is needed.
// The depth is set by the divider for the rotation coefficient s, which
// resolves one quotient bit per stage over 33 stages, around single
// multiplier stages for the kicks, the rotation and the drift.
// The user writes registers via cfg_we_i, cfg_idx_i and cfg_wdata_i only while
// no request is in flight, unenforced by the unit. Reset empties the pipeline
// and loads the default time step, charge-over-mass factor and box lengths.
// ----------------------------------------------------------------------------
module boris_particle_push_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic [30:0]        pos_x_i,
  input  logic [30:0]        pos_y_i,
  input  logic [30:0]        pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] e_x_i,
  input  logic signed [31:0] e_y_i,
  input  logic signed [31:0] e_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  output logic               done_o,
  output logic [30:0]        new_pos_x_o,
  output logic [30:0]        new_pos_y_o,
  output logic [30:0]        new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o
);

  logic [30:0] time_step_q;
  logic [31:0] half_dt_qm_q;
  logic [2:0][30:0] box_len_q;

  logic [bpp_pkg::NumStages-1:0] vld_q;
  bpp_pkg::push_t st_q [bpp_pkg::NumStages];
  bpp_pkg::push_t st_d [bpp_pkg::NumStages];

  logic [2:0][31:0] in_e;
  logic [2:0][31:0] in_b;

  assign busy_o = 1'b0;
  assign in_e = {e_z_i, e_y_i, e_x_i};
  assign in_b = {b_z_i, b_y_i, b_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q  <= bpp_pkg::TimeStepRst;
      half_dt_qm_q <= bpp_pkg::HalfDtQmRst;
      box_len_q    <= {3{bpp_pkg::BoxLenRst}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpp_pkg::CfgTimeStep: time_step_q  <= cfg_wdata_i[30:0];
        bpp_pkg::CfgHalfDtQm: half_dt_qm_q <= cfg_wdata_i;
        bpp_pkg::CfgBoxLenX:  box_len_q[0] <= cfg_wdata_i[30:0];
        bpp_pkg::CfgBoxLenY:  box_len_q[1] <= cfg_wdata_i[30:0];
        bpp_pkg::CfgBoxLenZ:  box_len_q[2] <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[bpp_pkg::NumStages-2:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < bpp_pkg::NumStages; n++) begin
      st_q[n] <= st_d[n];
    end
  end

  always_comb begin
    logic signed [41:0] acc;
    logic [31:0] mag;
    logic [56:0] nume;
    logic [32:0] rsh;
    logic [33:0] l34;
    logic [31:0] r;
    int unsigned a;
    int unsigned b;

    acc = '0;
    mag = '0;
    nume = '0;
    rsh = '0;
    l34 = '0;
    r = '0;
    a = 0;
    b = 0;

    st_d[0] = '0;
    for (int n = 1; n < bpp_pkg::NumStages; n++) begin
      st_d[n] = st_q[n-1];
    end

    st_d[0].pos = {pos_z_i, pos_y_i, pos_x_i};
    st_d[0].vel = {vel_z_i, vel_y_i, vel_x_i};
    for (int i = 0; i < 3; i++) begin
      st_d[0].prod_a[i] = bpp_pkg::mul_q(half_dt_qm_q, in_e[i]);
      st_d[0].prod_b[i] = bpp_pkg::mul_q(half_dt_qm_q, in_b[i]);
    end

    for (int i = 0; i < 3; i++) begin
      st_d[1].k[i] = bpp_pkg::rnd_q(st_q[0].prod_a[i]);
      st_d[1].t[i] = bpp_pkg::rnd_q(st_q[0].prod_b[i]);
    end

    for (int i = 0; i < 3; i++) begin
      st_d[2].vm[i] = bpp_pkg::sat_q(bpp_pkg::ext_q(st_q[1].vel[i])
                                     + bpp_pkg::ext_q(st_q[1].k[i]));
      st_d[2].prod_a[i] = bpp_pkg::mul_q(st_q[1].t[i], st_q[1].t[i]);
    end

    acc = bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[2].prod_a[0]))
        + bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[2].prod_a[1]))
        + bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[2].prod_a[2]));
    st_d[3].den = 32'h0100_0000 + bpp_pkg::sat_q(acc);
    for (int i = 0; i < 3; i++) begin
      a = bpp_pkg::Next1[i];
      b = bpp_pkg::Next2[i];
      st_d[3].prod_a[i] = bpp_pkg::mul_q(st_q[2].vm[a], st_q[2].t[b]);
      st_d[3].prod_b[i] = bpp_pkg::mul_q(st_q[2].vm[b], st_q[2].t[a]);
    end

    for (int i = 0; i < 3; i++) begin
      st_d[4].vp[i] = bpp_pkg::sat_q(bpp_pkg::ext_q(st_q[3].vm[i])
                      + bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[3].prod_a[i]))
                      - bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[3].prod_b[i])));
      st_d[4].neg[i] = st_q[3].t[i][31];
      mag = st_q[3].t[i][31] ? (32'd0 - st_q[3].t[i]) : st_q[3].t[i];
      nume = {mag, 25'd0} + {25'd0, 1'b0, st_q[3].den[31:1]};
      st_d[4].rem[i] = {8'd0, nume[56:33]};
      st_d[4].num[i] = nume[32:0];
      st_d[4].quo[i] = '0;
    end

    for (int j = 0; j < bpp_pkg::DivSteps; j++) begin
      for (int i = 0; i < 3; i++) begin
        rsh = {st_q[bpp_pkg::DivFirst+j-1].rem[i],
               st_q[bpp_pkg::DivFirst+j-1].num[i][32]};
        st_d[bpp_pkg::DivFirst+j].num[i] = {st_q[bpp_pkg::DivFirst+j-1].num[i][31:0], 1'b0};
        if (rsh >= {1'b0, st_q[bpp_pkg::DivFirst+j-1].den}) begin
          st_d[bpp_pkg::DivFirst+j].rem[i] =
            32'(rsh - {1'b0, st_q[bpp_pkg::DivFirst+j-1].den});
          st_d[bpp_pkg::DivFirst+j].quo[i] =
            {st_q[bpp_pkg::DivFirst+j-1].quo[i][31:0], 1'b1};
        end else begin
          st_d[bpp_pkg::DivFirst+j].rem[i] = rsh[31:0];
          st_d[bpp_pkg::DivFirst+j].quo[i] =
            {st_q[bpp_pkg::DivFirst+j-1].quo[i][31:0], 1'b0};
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      acc = $signed({9'd0, st_q[37].quo[i]});
      st_d[38].s[i] = bpp_pkg::sat_q(st_q[37].neg[i] ? -acc : acc);
    end

    for (int i = 0; i < 3; i++) begin
      a = bpp_pkg::Next1[i];
      b = bpp_pkg::Next2[i];
      st_d[39].prod_a[i] = bpp_pkg::mul_q(st_q[38].vp[a], st_q[38].s[b]);
      st_d[39].prod_b[i] = bpp_pkg::mul_q(st_q[38].vp[b], st_q[38].s[a]);
    end

    for (int i = 0; i < 3; i++) begin
      st_d[40].vn[i] = bpp_pkg::sat_q(bpp_pkg::ext_q(st_q[39].vm[i])
                       + bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[39].prod_a[i]))
                       - bpp_pkg::ext_q(bpp_pkg::rnd_q(st_q[39].prod_b[i])));
    end

    for (int i = 0; i < 3; i++) begin
      st_d[41].vn[i] = bpp_pkg::sat_q(bpp_pkg::ext_q(st_q[40].vn[i])
                                      + bpp_pkg::ext_q(st_q[40].k[i]));
    end

    for (int i = 0; i < 3; i++) begin
      st_d[42].prod_a[i] = bpp_pkg::mul_q(st_q[41].vn[i], {1'b0, time_step_q});
    end

    for (int i = 0; i < 3; i++) begin
      r = bpp_pkg::rnd_q(st_q[42].prod_a[i]);
      st_d[43].pw[i] = {3'd0, st_q[42].pos[i]} + {{2{r[31]}}, r};
    end

    for (int i = 0; i < 3; i++) begin
      l34 = {3'd0, box_len_q[i]};
      if (st_q[43].pw[i][33]) begin
        st_d[44].pw[i] = st_q[43].pw[i] + l34;
      end else if ($signed(st_q[43].pw[i]) >= $signed(l34)) begin
        st_d[44].pw[i] = st_q[43].pw[i] - l34;
      end
    end

    for (int i = 0; i < 3; i++) begin
      l34 = {3'd0, box_len_q[i]};
      if (box_len_q[i] == 31'd0 || st_q[44].pw[i][33]) begin
        st_d[45].pos[i] = '0;
      end else if ($signed(st_q[44].pw[i]) >= $signed(l34)) begin
        st_d[45].pos[i] = box_len_q[i] - 31'd1;
      end else begin
        st_d[45].pos[i] = st_q[44].pw[i][30:0];
      end
    end
  end

  assign done_o      = vld_q[bpp_pkg::NumStages-1];
  assign new_pos_x_o = st_q[bpp_pkg::NumStages-1].pos[0];
  assign new_pos_y_o = st_q[bpp_pkg::NumStages-1].pos[1];
  assign new_pos_z_o = st_q[bpp_pkg::NumStages-1].pos[2];
  assign new_vel_x_o = st_q[bpp_pkg::NumStages-1].vn[0];
  assign new_vel_y_o = st_q[bpp_pkg::NumStages-1].vn[1];
  assign new_vel_z_o = st_q[bpp_pkg::NumStages-1].vn[2];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point Boris particle push unit.
// ----------------------------------------------------------------------------
// Particles are sent as requests with random gaps. Each accepted request is
// pushed through a bit-exact model of the kick, rotation, drift and periodic
// wrap, and each result marked by done_o is compared with the oldest
// prediction. Registers are rewritten between batches, with the pipeline
// drained, to sweep time step, charge-over-mass and box lengths.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdleLimit = 3000;
  localparam logic [2:0] CfgIdxFirstFree = 3'd5;
  localparam logic [2:0] CfgIdxBeyond = 3'd6;
  localparam logic [2:0] CfgIdxTop = 3'd7;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam longint QOne = 64'sd16777216;

  typedef struct packed {
    logic [2:0][30:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] e;
    logic [2:0][31:0] b;
  } particle_t;

  typedef struct packed {
    logic [2:0][30:0] pos;
    logic [2:0][31:0] vel;
  } pushed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  particle_t req_q = '0;
  logic done_o;
  pushed_t res;

  logic [30:0] dt_reg = bpp_pkg::TimeStepRst;
  logic [31:0] hqm_reg = bpp_pkg::HalfDtQmRst;
  logic [2:0][30:0] box_reg = {bpp_pkg::BoxLenRst, bpp_pkg::BoxLenRst, bpp_pkg::BoxLenRst};

  pushed_t pending_pushes[$];
  int unsigned n_errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  boris_particle_push_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_x_i     (req_q.pos[0]),
    .pos_y_i     (req_q.pos[1]),
    .pos_z_i     (req_q.pos[2]),
    .vel_x_i     (req_q.vel[0]),
    .vel_y_i     (req_q.vel[1]),
    .vel_z_i     (req_q.vel[2]),
    .e_x_i       (req_q.e[0]),
    .e_y_i       (req_q.e[1]),
    .e_z_i       (req_q.e[2]),
    .b_x_i       (req_q.b[0]),
    .b_y_i       (req_q.b[1]),
    .b_z_i       (req_q.b[2]),
    .done_o      (done_o),
    .new_pos_x_o (res.pos[0]),
    .new_pos_y_o (res.pos[1]),
    .new_pos_z_o (res.pos[2]),
    .new_vel_x_o (res.vel[0]),
    .new_vel_y_o (res.vel[1]),
    .new_vel_z_o (res.vel[2])
  );

  function automatic longint clamp_q(longint x);
    if (x > QMax) return QMax;
    if (x < QMin) return QMin;
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint x;
    x = a * b + QOne / 2;
    return clamp_q(x >>> 24);
  endfunction

  function automatic longint rot_coef(longint t, longint den);
    longint num, mag, q;
    num = 2 * t * QOne;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return clamp_q((num < 0) ? -q : q);
  endfunction

  function automatic logic [30:0] wrap_pos(longint p, longint l);
    if (l == 0) return '0;
    if (p < 0) p += l;
    else if (p >= l) p -= l;
    if (p < 0) p = 0;
    if (p >= l) p = l - 1;
    return p[30:0];
  endfunction

  function automatic pushed_t boris_push(particle_t pt);
    longint h, tmag, den, vplus;
    longint k[3], t[3], s[3], vm[3], vp[3], vn[3];
    int a, c;
    pushed_t r;
    h = longint'($signed(hqm_reg));
    for (int i = 0; i < 3; i++) begin
      k[i] = fx_mul(h, longint'($signed(pt.e[i])));
      t[i] = fx_mul(h, longint'($signed(pt.b[i])));
      vm[i] = clamp_q(longint'($signed(pt.vel[i])) + k[i]);
    end
    tmag = clamp_q(fx_mul(t[0], t[0]) + fx_mul(t[1], t[1]) + fx_mul(t[2], t[2]));
    den = QOne + tmag;
    for (int i = 0; i < 3; i++) s[i] = rot_coef(t[i], den);
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      c = (i + 2) % 3;
      vp[i] = clamp_q(vm[i] + fx_mul(vm[a], t[c]) - fx_mul(vm[c], t[a]));
    end
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      c = (i + 2) % 3;
      vplus = clamp_q(vm[i] + fx_mul(vp[a], s[c]) - fx_mul(vp[c], s[a]));
      vn[i] = clamp_q(vplus + k[i]);
    end
    for (int i = 0; i < 3; i++) begin
      r.vel[i] = vn[i][31:0];
      r.pos[i] = wrap_pos(longint'({33'd0, pt.pos[i]}) +
                          fx_mul(vn[i], longint'({33'd0, dt_reg})),
                          longint'({33'd0, box_reg[i]}));
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    pushed_t exp_r;
    if (done_o) begin
      n_results++;
      if (pending_pushes.size() == 0) begin
        n_errors++;
        $display("%0t: result with no request pending", $time);
      end else begin
        exp_r = pending_pushes.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (res.pos[i] !== exp_r.pos[i]) begin
            n_errors++;
            $display("%0t: new_pos[%0d] expected %h actual %h", $time, i,
                     exp_r.pos[i], res.pos[i]);
          end
          if (res.vel[i] !== exp_r.vel[i]) begin
            n_errors++;
            $display("%0t: new_vel[%0d] expected %h actual %h", $time, i,
                     exp_r.vel[i], res.vel[i]);
          end
        end
      end
    end
    if (done_o || (start_i && !busy_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("boris_particle_push_unit test failed");
      $finish;
    end
  end

  task automatic send_particle(particle_t pt);
    int unsigned gap;
    start_i <= 1'b1;
    req_q <= pt;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    pending_pushes.push_back(boris_push(pt));
    n_requests++;
    if ($urandom_range(0, 9) < 6) gap = 0;
    else if ($urandom_range(0, 9) != 0) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_pushes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_cfg_writes++;
    case (idx)
      bpp_pkg::CfgTimeStep: dt_reg = val[30:0];
      bpp_pkg::CfgHalfDtQm: hqm_reg = val;
      bpp_pkg::CfgBoxLenX:  box_reg[0] = val[30:0];
      bpp_pkg::CfgBoxLenY:  box_reg[1] = val[30:0];
      bpp_pkg::CfgBoxLenZ:  box_reg[2] = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [31:0] dt, logic [31:0] hqm, logic [31:0] lx,
                              logic [31:0] ly, logic [31:0] lz);
    write_reg(bpp_pkg::CfgTimeStep, dt);
    write_reg(bpp_pkg::CfgHalfDtQm, hqm);
    write_reg(bpp_pkg::CfgBoxLenX, lx);
    write_reg(bpp_pkg::CfgBoxLenY, ly);
    write_reg(bpp_pkg::CfgBoxLenZ, lz);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      2: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t pt;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 7) == 0 || box_reg[i] == 0) pt.pos[i] = 31'($urandom());
      else pt.pos[i] = 31'($urandom_range(0, box_reg[i] - 1));
      pt.vel[i] = rand_value();
      pt.e[i] = rand_value();
      pt.b[i] = rand_value();
    end
    return pt;
  endfunction

  task automatic test_directed_particles();
    particle_t pt;
    pt = '0;
    send_particle(pt);
    pt.pos = {3{31'h7FFF_FFFF}};
    pt.vel = {3{32'h7FFF_FFFF}};
    pt.e = {3{32'h7FFF_FFFF}};
    pt.b = {3{32'h7FFF_FFFF}};
    send_particle(pt);
    pt.vel = {3{32'h8000_0000}};
    pt.e = {3{32'h8000_0000}};
    pt.b = {3{32'h8000_0000}};
    send_particle(pt);
    pt = '0;
    pt.pos = {3{31'd268435455}};
    pt.vel = {3{32'h0100_0000}};
    send_particle(pt);
    pt.pos = '0;
    pt.vel = {3{32'hFF00_0000}};
    send_particle(pt);
    pt.vel = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    pt.b = {32'h0100_0000, 32'h0, 32'hFF00_0000};
    send_particle(pt);
    pt = '0;
    pt.b = {32'h0, 32'h0, 32'h4000_0000};
    pt.vel = {32'h0, 32'h0, 32'h0200_0000};
    pt.e = {32'h0, 32'h0100_0000, 32'h0};
    send_particle(pt);
    pt.pos = {31'h7000_0000, 31'h1000_0000, 31'h0FFF_FFFF};
    send_particle(pt);
    drain();
  endtask

  task automatic test_register_extremes();
    particle_t pt;
    logic [31:0] settings [6][5];
    settings = '{
      '{32'h0, 32'h0, 32'h1, 32'h1, 32'h1},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0},
      '{32'h0100_0000, 32'h0080_0000, 32'h0200_0000, 32'h0010_0000, 32'h7FFF_FFFF},
      '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0400_0000, 32'h0000_0003},
      '{32'h0010_0000, 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0080_0000}};
    for (int s = 0; s < 6; s++) begin
      load_setting(settings[s][0], settings[s][1], settings[s][2], settings[s][3],
                   settings[s][4]);
      pt = '0;
      pt.pos = {3{31'h7FFF_FFFF}};
      pt.vel = {3{32'h7FFF_FFFF}};
      send_particle(pt);
      for (int n = 0; n < 30; n++) send_particle(rand_particle());
      drain();
    end
    write_reg(CfgIdxBeyond, $urandom());
    write_reg(CfgIdxTop, $urandom());
    write_reg(CfgIdxFirstFree, $urandom());
    for (int n = 0; n < 20; n++) send_particle(rand_particle());
    drain();
  endtask

  task automatic test_random_batches();
    logic [31:0] lens [3];
    for (int batch = 0; batch < 8; batch++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 3))
          0: lens[i] = $urandom();
          1: lens[i] = $urandom_range(1, 32'h0100_0000);
          default: lens[i] = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
        endcase
      end
      load_setting(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0200_0000),
                   ($urandom_range(0, 3) == 0) ? $urandom() : rand_value(),
                   lens[0], lens[1], lens[2]);
      for (int n = 0; n < 190; n++) send_particle(rand_particle());
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_particles();
    test_register_extremes();
    test_random_batches();
    $display("Pushed %0d particles, checked %0d results, %0d register writes.",
             n_requests, n_results, n_cfg_writes);
    $display("Settings swept: zero and full time step, both charge signs, box 0 to max.");
    if (n_errors == 0 && pending_pushes.size() == 0) begin
      $display("boris_particle_push_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, pending_pushes.size());
      $display("boris_particle_push_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/bpp_pkg.sv
sv/boris_particle_push_unit.sv
tb/sv/tb.sv
